// File: src/hur_pkg.sv
// ----------------------------------------------------------------------------
// HTTP URL recognizer package
// Shared types and constants of the URL recognizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hur_pkg;

   typedef enum logic [2:0] {
      PH_SCHEME = 3'd0,
      PH_SEP    = 3'd1,
      PH_HOST   = 3'd2,
      PH_PORT   = 3'd3,
      PH_PATH   = 3'd4,
      PH_FAIL   = 3'd5
   } phase_type;

   localparam logic [2:0] SEG_SCHEME = 3'd0;
   localparam logic [2:0] SEG_SEP    = 3'd1;
   localparam logic [2:0] SEG_HOST   = 3'd2;
   localparam logic [2:0] SEG_PORT   = 3'd3;
   localparam logic [2:0] SEG_PATH   = 3'd4;
   localparam logic [2:0] SEG_REJECT = 3'd5;

   localparam logic [1:0] ERR_NONE   = 2'd0;
   localparam logic [1:0] ERR_SYNTAX = 2'd1;
   localparam logic [1:0] ERR_PORT   = 2'd2;

   localparam logic [15:0] HTTP_PORT  = 16'd80;
   localparam logic [15:0] HTTPS_PORT = 16'd443;
   localparam logic [19:0] PORT_MAX   = 20'd65535;
   localparam logic [16:0] PORT_MIN   = 17'd1;
   localparam logic [16:0] PORT_SAT   = 17'h10000;

   typedef struct packed {
      phase_type   phase;
      logic [2:0]  scheme_index;
      logic        scheme_https;
      logic [1:0]  label_length;
      logic        label_letters_only;
      logic        host_has_dot;
      logic [16:0] port_accum;
      logic        port_overflow;
      logic        port_digits_seen;
      logic        path_seen;
   } parse_state_type;

   localparam parse_state_type PARSE_RESET = '{
      phase:              PH_SCHEME,
      scheme_index:       3'd0,
      scheme_https:       1'b0,
      label_length:       2'd0,
      label_letters_only: 1'b1,
      host_has_dot:       1'b0,
      port_accum:         17'd0,
      port_overflow:      1'b0,
      port_digits_seen:   1'b0,
      path_seen:          1'b0
   };

   typedef struct packed {
      logic [2:0]  segment;
      logic        url_done;
      logic        url_valid;
      logic [1:0]  error_code;
      logic        is_https;
      logic [15:0] port_number;
      logic        port_is_default;
      logic        path_defaulted;
   } url_result_type;

endpackage

`default_nettype wire

// File: src/hur_step.sv
// ----------------------------------------------------------------------------
// HTTP URL recognizer step
// Next parse state and the result beat for one URL byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hur_step (
   input  wire  hur_pkg::parse_state_type cur_state,
   input  wire  logic [7:0]               char_in,
   input  wire  logic                     last_char,
   output hur_pkg::parse_state_type       nxt_state,
   output hur_pkg::url_result_type        result
);

   logic [7:0]  lc;
   logic        is_alpha;
   logic        is_digit;
   logic        is_path;
   logic [7:0]  scheme_char;
   logic [19:0] port_sum;
   logic        host_done;
   logic        ok_end;
   logic [15:0] def_port;

   assign is_alpha = (char_in >= "a" && char_in <= "z") || (char_in >= "A" && char_in <= "Z");
   assign is_digit = (char_in >= "0" && char_in <= "9");
   assign lc = (char_in >= "A" && char_in <= "Z") ? char_in + 8'd32 : char_in;

   always_comb begin
      case (cur_state.scheme_index[1:0])
         2'd0:    scheme_char = "h";
         2'd1:    scheme_char = "t";
         2'd2:    scheme_char = "t";
         default: scheme_char = "p";
      endcase
   end

   always_comb begin
      case (char_in)
         "-", ".", "_", "~", "!", "$", "&", "'", "(", ")", "*", "+", ",", ";",
         "=", ":", "@", "/", "%": is_path = 1'b1;
         default:                 is_path = is_alpha || is_digit;
      endcase
   end

   assign port_sum = ({3'd0, cur_state.port_accum} << 3) + ({3'd0, cur_state.port_accum} << 1)
                   + {16'd0, char_in[3:0]};

   assign host_done = cur_state.host_has_dot && (cur_state.label_length == 2'd2)
                    && cur_state.label_letters_only;

   always_comb begin
      nxt_state = cur_state;
      unique case (cur_state.phase)
         hur_pkg::PH_SCHEME: begin
            if (cur_state.scheme_index < 3'd4) begin
               if (lc == scheme_char) begin
                  nxt_state.scheme_index = cur_state.scheme_index + 3'd1;
               end else begin
                  nxt_state.phase = hur_pkg::PH_FAIL;
               end
            end else if (cur_state.scheme_index == 3'd4 && lc == "s") begin
               nxt_state.scheme_https = 1'b1;
               nxt_state.scheme_index = 3'd5;
            end else if (char_in == ":") begin
               nxt_state.phase        = hur_pkg::PH_SEP;
               nxt_state.scheme_index = 3'd1;
            end else begin
               nxt_state.phase = hur_pkg::PH_FAIL;
            end
         end
         hur_pkg::PH_SEP: begin
            if (char_in != "/") begin
               nxt_state.phase = hur_pkg::PH_FAIL;
            end else if (cur_state.scheme_index >= 3'd2) begin
               nxt_state.phase        = hur_pkg::PH_HOST;
               nxt_state.scheme_index = 3'd0;
            end else begin
               nxt_state.scheme_index = cur_state.scheme_index + 3'd1;
            end
         end
         hur_pkg::PH_HOST: begin
            if (is_alpha || is_digit || char_in == "-") begin
               if (cur_state.label_length != 2'd2) begin
                  nxt_state.label_length = cur_state.label_length + 2'd1;
               end
               if (!is_alpha) begin
                  nxt_state.label_letters_only = 1'b0;
               end
            end else if (char_in == ".") begin
               if (cur_state.label_length == 2'd0) begin
                  nxt_state.phase = hur_pkg::PH_FAIL;
               end else begin
                  nxt_state.host_has_dot       = 1'b1;
                  nxt_state.label_length       = 2'd0;
                  nxt_state.label_letters_only = 1'b1;
               end
            end else if (char_in == ":" && host_done) begin
               nxt_state.phase = hur_pkg::PH_PORT;
            end else if (char_in == "/" && host_done) begin
               nxt_state.phase     = hur_pkg::PH_PATH;
               nxt_state.path_seen = 1'b1;
            end else begin
               nxt_state.phase = hur_pkg::PH_FAIL;
            end
         end
         hur_pkg::PH_PORT: begin
            if (is_digit) begin
               nxt_state.port_digits_seen = 1'b1;
               if (port_sum > hur_pkg::PORT_MAX) begin
                  nxt_state.port_overflow = 1'b1;
                  nxt_state.port_accum    = hur_pkg::PORT_SAT;
               end else begin
                  nxt_state.port_accum = port_sum[16:0];
               end
            end else if (char_in == "/" && cur_state.port_digits_seen) begin
               nxt_state.phase     = hur_pkg::PH_PATH;
               nxt_state.path_seen = 1'b1;
            end else begin
               nxt_state.phase = hur_pkg::PH_FAIL;
            end
         end
         hur_pkg::PH_PATH: begin
            if (!is_path) begin
               nxt_state.phase = hur_pkg::PH_FAIL;
            end
         end
         default: begin
            nxt_state.phase = hur_pkg::PH_FAIL;
         end
      endcase
   end

   assign ok_end = (nxt_state.phase == hur_pkg::PH_HOST && nxt_state.host_has_dot
                    && nxt_state.label_length == 2'd2 && nxt_state.label_letters_only)
                || (nxt_state.phase == hur_pkg::PH_PORT && nxt_state.port_digits_seen)
                || (nxt_state.phase == hur_pkg::PH_PATH);

   assign def_port = nxt_state.scheme_https ? hur_pkg::HTTPS_PORT : hur_pkg::HTTP_PORT;

   always_comb begin
      result = '0;
      unique case (nxt_state.phase)
         hur_pkg::PH_SCHEME: result.segment = hur_pkg::SEG_SCHEME;
         hur_pkg::PH_SEP:    result.segment = hur_pkg::SEG_SEP;
         hur_pkg::PH_HOST: begin
            result.segment = (cur_state.phase == hur_pkg::PH_SEP) ? hur_pkg::SEG_SEP
                                                                   : hur_pkg::SEG_HOST;
         end
         hur_pkg::PH_PORT:   result.segment = hur_pkg::SEG_PORT;
         hur_pkg::PH_PATH:   result.segment = hur_pkg::SEG_PATH;
         default:            result.segment = hur_pkg::SEG_REJECT;
      endcase
      if (last_char) begin
         result.url_done = 1'b1;
         if (nxt_state.phase == hur_pkg::PH_FAIL || !ok_end) begin
            result.error_code = hur_pkg::ERR_SYNTAX;
         end else if (nxt_state.port_digits_seen && (nxt_state.port_overflow
                      || nxt_state.port_accum < hur_pkg::PORT_MIN)) begin
            result.error_code = hur_pkg::ERR_PORT;
         end else begin
            result.error_code  = hur_pkg::ERR_NONE;
            result.url_valid   = 1'b1;
            result.is_https    = nxt_state.scheme_https;
            result.port_number = nxt_state.port_digits_seen ? nxt_state.port_accum[15:0]
                                                            : def_port;
            result.port_is_default = (result.port_number == def_port);
            result.path_defaulted  = !nxt_state.path_seen;
         end
      end
   end

endmodule

`default_nettype wire

// File: src/http_url_recognizer_unit.sv
// ----------------------------------------------------------------------------
// HTTP URL recognizer
// Checks http and https URLs byte by byte and tags each byte with its part.
// ----------------------------------------------------------------------------
// The block takes one URL byte per beat and returns one result beat per byte
// in the cycle after the byte is taken, so it sustains one byte per clock while
// rsp_tready stays high. The parse state is registered and the result sits in
// an output register; a new byte is taken whenever that register is empty or
// is being drained in the same cycle. The result of the last byte carries the
// verdict, and the parser is back at its start state for the next URL right after it.
`timescale 1ns / 1ps
`default_nettype none

module http_url_recognizer_unit (
   input  wire  logic        clock,
   input  wire  logic        reset,
   input  wire  logic        req_tvalid,
   output logic              req_tready,
   input  wire  logic [7:0]  req_tdata,   // [7:0] char_in
   input  wire  logic        req_tlast,   // last_char
   output logic              rsp_tvalid,
   input  wire  logic        rsp_tready,
   output logic [23:0]       rsp_tdata,   // [0] url_valid, [2:1] error_code,
                                          // [3] is_https, [19:4] port_number,
                                          // [20] port_is_default,
                                          // [21] path_defaulted, [23:22] zero
   output logic [2:0]        rsp_tuser,   // [2:0] segment
   output logic              rsp_tlast    // url_done
);

   hur_pkg::parse_state_type state_ff;
   hur_pkg::parse_state_type state_in;
   hur_pkg::parse_state_type step_state;
   hur_pkg::url_result_type  step_result;
   hur_pkg::url_result_type  result_ff;
   logic                     valid_ff;
   logic                     valid_in;
   logic                     take;

   hur_step u_step (
      .cur_state (state_ff),
      .char_in   (req_tdata),
      .last_char (req_tlast),
      .nxt_state (step_state),
      .result    (step_result)
   );

   assign req_tready = !valid_ff || rsp_tready;
   assign take       = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      valid_in = valid_ff && !rsp_tready;
      if (take) begin
         state_in = req_tlast ? hur_pkg::PARSE_RESET : step_state;
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hur_pkg::PARSE_RESET;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         result_ff <= step_result;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tuser  = result_ff.segment;
   assign rsp_tlast  = result_ff.url_done;
   assign rsp_tdata  = {2'b00, result_ff.path_defaulted, result_ff.port_is_default,
                        result_ff.port_number, result_ff.is_https, result_ff.error_code,
                        result_ff.url_valid};

endmodule

`default_nettype wire
